// ----- rtl/core/jehl_pkg.sv -----
package jehl_pkg;

  // Parser phases, one-hot
  typedef enum logic [10:0] {
    PH_SOI0    = 11'b000_0000_0001,
    PH_SOI1    = 11'b000_0000_0010,
    PH_MARK_FF = 11'b000_0000_0100,
    PH_MARK_ID = 11'b000_0000_1000,
    PH_SEG_LEN = 11'b000_0001_0000,
    PH_SKIP    = 11'b000_0010_0000,
    PH_APP_LEN = 11'b000_0100_0000,
    PH_SIG     = 11'b000_1000_0000,
    PH_ORDER   = 11'b001_0000_0000,
    PH_MAGIC   = 11'b010_0000_0000,
    PH_OFFSET  = 11'b100_0000_0000
  } phase_t;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SOI    = 3'd1;
  localparam logic [2:0] ST_NO_MARKER = 3'd2;
  localparam logic [2:0] ST_BAD_SIG   = 3'd3;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd4;
  localparam logic [2:0] ST_BAD_LEN   = 3'd5;

  // Stream constants
  localparam logic [7:0]  MARKER_FF   = 8'hFF;
  localparam logic [7:0]  SOI_ID      = 8'hD8;
  localparam logic [7:0]  APP1_ID     = 8'hE1;
  localparam logic [7:0]  ORDER_II    = 8'h49;
  localparam logic [15:0] TIFF_MAGIC  = 16'h002A;
  localparam logic [15:0] SEG_LEN_MIN = 16'd2;
  localparam logic [15:0] APP_LEN_MIN = 16'd16;
  localparam logic [2:0]  SIG_LAST    = 3'd5;
  localparam logic [2:0]  OFF_LAST    = 3'd3;
  localparam logic [32:0] POS_BIAS    = 33'd6;

  // Parser state carried between bytes
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  byte_count;
    logic [15:0] skip_left;
    logic [31:0] gather_word;
    logic        order_flag;
    logic        finished;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase:       PH_SOI0,
    byte_count:  3'd0,
    skip_left:   16'd0,
    gather_word: 32'd0,
    order_flag:  1'b0,
    finished:    1'b0
  };

  // One result item
  typedef struct packed {
    logic [2:0]  status;
    logic        little_endian;
    logic [31:0] ifd_ptr;
  } parse_result_t;

  // "Exif" followed by two zero bytes; index wraps modulo six
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h45;
      3'd1:    r = 8'h78;
      3'd2:    r = 8'h69;
      3'd3:    r = 8'h66;
      3'd4:    r = 8'h00;
      3'd5:    r = 8'h00;
      3'd6:    r = 8'h45;
      default: r = 8'h78;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/jehl_step.sv -----
// Next-state and result logic for one stream byte
module jehl_step (
  input  jehl_pkg::parse_state_t  cur,
  input  logic [7:0]              data_byte,
  input  logic                    first_byte,
  output jehl_pkg::parse_state_t  nxt,
  output logic                    emit,
  output jehl_pkg::parse_result_t res
);

  jehl_pkg::parse_state_t s;
  logic [15:0] gw16;
  logic [15:0] seg_rem;
  logic [15:0] magic_v;
  logic [31:0] gw32;
  logic [31:0] off_v;
  logic        is_ii;

  // Start of file restarts the parse with this byte
  assign s = first_byte ? jehl_pkg::PARSE_CLEAR : cur;

  assign gw16    = {s.gather_word[7:0], data_byte};
  assign gw32    = {s.gather_word[23:0], data_byte};
  assign seg_rem = gw16 - jehl_pkg::SEG_LEN_MIN;
  assign is_ii   = (data_byte == jehl_pkg::ORDER_II);
  assign magic_v = s.order_flag ? {data_byte, s.gather_word[7:0]} : gw16;
  assign off_v   = s.order_flag ? {gw32[7:0], gw32[15:8], gw32[23:16], gw32[31:24]} : gw32;

  always_comb begin
    nxt  = s;
    emit = 1'b0;
    res  = '0;
    if (!s.finished) begin
      unique case (s.phase)
        jehl_pkg::PH_SOI0: begin
          if (data_byte != jehl_pkg::MARKER_FF) begin
            emit       = 1'b1;
            res.status = jehl_pkg::ST_NO_SOI;
          end else begin
            nxt.phase = jehl_pkg::PH_SOI1;
          end
        end
        jehl_pkg::PH_SOI1: begin
          if (data_byte != jehl_pkg::SOI_ID) begin
            emit       = 1'b1;
            res.status = jehl_pkg::ST_NO_SOI;
          end else begin
            nxt.phase = jehl_pkg::PH_MARK_FF;
          end
        end
        jehl_pkg::PH_MARK_FF: begin
          if (data_byte != jehl_pkg::MARKER_FF) begin
            emit       = 1'b1;
            res.status = jehl_pkg::ST_NO_MARKER;
          end else begin
            nxt.phase = jehl_pkg::PH_MARK_ID;
          end
        end
        jehl_pkg::PH_MARK_ID: begin
          nxt.byte_count  = 3'd0;
          nxt.gather_word = 32'd0;
          nxt.phase       = (data_byte == jehl_pkg::APP1_ID) ? jehl_pkg::PH_APP_LEN
                                                             : jehl_pkg::PH_SEG_LEN;
        end
        jehl_pkg::PH_SEG_LEN: begin
          nxt.gather_word = {16'd0, gw16};
          if (s.byte_count == 3'd0) begin
            nxt.byte_count = 3'd1;
          end else begin
            nxt.byte_count = 3'd0;
            if (gw16 < jehl_pkg::SEG_LEN_MIN) begin
              emit       = 1'b1;
              res.status = jehl_pkg::ST_BAD_LEN;
            end else begin
              nxt.skip_left   = seg_rem;
              nxt.gather_word = 32'd0;
              nxt.phase       = (seg_rem == 16'd0) ? jehl_pkg::PH_MARK_FF
                                                   : jehl_pkg::PH_SKIP;
            end
          end
        end
        jehl_pkg::PH_SKIP: begin
          nxt.skip_left = s.skip_left - 16'd1;
          if (s.skip_left == 16'd1) nxt.phase = jehl_pkg::PH_MARK_FF;
        end
        jehl_pkg::PH_APP_LEN: begin
          nxt.gather_word = {16'd0, gw16};
          if (s.byte_count == 3'd0) begin
            nxt.byte_count = 3'd1;
          end else begin
            nxt.byte_count = 3'd0;
            if (gw16 < jehl_pkg::APP_LEN_MIN) begin
              emit       = 1'b1;
              res.status = jehl_pkg::ST_BAD_LEN;
            end else begin
              nxt.gather_word = 32'd0;
              nxt.phase       = jehl_pkg::PH_SIG;
            end
          end
        end
        jehl_pkg::PH_SIG: begin
          if (data_byte != jehl_pkg::sig_byte(s.byte_count)) begin
            emit       = 1'b1;
            res.status = jehl_pkg::ST_BAD_SIG;
          end else if (s.byte_count >= jehl_pkg::SIG_LAST) begin
            nxt.byte_count = 3'd0;
            nxt.phase      = jehl_pkg::PH_ORDER;
          end else begin
            nxt.byte_count = s.byte_count + 3'd1;
          end
        end
        jehl_pkg::PH_ORDER: begin
          if (s.byte_count == 3'd0) begin
            nxt.order_flag = is_ii;
            nxt.byte_count = 3'd1;
          end else begin
            nxt.order_flag  = s.order_flag & is_ii;
            nxt.byte_count  = 3'd0;
            nxt.gather_word = 32'd0;
            nxt.phase       = jehl_pkg::PH_MAGIC;
          end
        end
        jehl_pkg::PH_MAGIC: begin
          nxt.gather_word = {16'd0, gw16};
          if (s.byte_count == 3'd0) begin
            nxt.byte_count = 3'd1;
          end else if (magic_v != jehl_pkg::TIFF_MAGIC) begin
            emit       = 1'b1;
            res.status = jehl_pkg::ST_BAD_MAGIC;
          end else begin
            nxt.byte_count  = 3'd0;
            nxt.gather_word = 32'd0;
            nxt.phase       = jehl_pkg::PH_OFFSET;
          end
        end
        jehl_pkg::PH_OFFSET: begin
          nxt.gather_word = gw32;
          if (s.byte_count == jehl_pkg::OFF_LAST) begin
            nxt.byte_count    = 3'd0;
            emit              = 1'b1;
            res.status        = jehl_pkg::ST_OK;
            res.little_endian = s.order_flag;
            res.ifd_ptr       = off_v;
          end else begin
            nxt.byte_count = s.byte_count + 3'd1;
          end
        end
        default: begin
          nxt = jehl_pkg::PARSE_CLEAR;
        end
      endcase
      // Any result ends parsing until the next file start
      if (emit) nxt.finished = 1'b1;
    end
  end

endmodule

// ----- rtl/core/jpeg_exif_header_locator_unit.sv -----
// Locates the Exif TIFF header in a JPEG byte stream. One byte is taken per
// cycle, back to back; in_first_byte marks the first byte of a file and
// restarts the parse. The parser checks the FF D8 start marker, skips
// non-APP1 segments by their length, checks the Exif signature, reads the
// byte order (II, else big-endian) and checks the TIFF magic, and gives
// one result per file (success or first error) in the cycle after the
// deciding byte is transferred. Bytes after the result are ignored until
// the next file start; a truncated file gives no result. Throughput is
// one byte per clock, set by the single result register: the input stalls
// only while that register holds a result that the output side is stalling.
module jpeg_exif_header_locator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_little_endian,
  output logic [31:0] out_ifd_ptr,
  output logic [32:0] out_ifd_position
);

  jehl_pkg::parse_state_t  st_r;
  jehl_pkg::parse_state_t  st_nxt;
  jehl_pkg::parse_result_t res_nxt;
  logic                    emit;
  logic                    in_xfer;
  logic                    out_valid_r;
  logic [2:0]              status_r;
  logic                    le_r;
  logic [31:0]             offset_r;
  logic [32:0]             position_r;

  jehl_step u_step (
    .cur        (st_r),
    .data_byte  (in_data_byte),
    .first_byte (in_first_byte),
    .nxt        (st_nxt),
    .emit       (emit),
    .res        (res_nxt)
  );

  // Input stalls only behind a held result
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= jehl_pkg::PARSE_CLEAR;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      status_r   <= res_nxt.status;
      le_r       <= res_nxt.little_endian;
      offset_r   <= res_nxt.ifd_ptr;
      position_r <= {1'b0, res_nxt.ifd_ptr} + jehl_pkg::POS_BIAS;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_little_endian = le_r;
  assign out_ifd_ptr       = offset_r;
  assign out_ifd_position  = position_r;

endmodule
